>>> design/lrcc_pkg.sv
package lrcc_pkg;

  localparam int DISP_W    = 8;
  localparam int CLASS_W   = 2;
  localparam int COL_W     = 9;
  localparam int WIN_DEPTH = 256;
  localparam int PTR_W     = 8;

  localparam logic [COL_W-1:0]   COL_MAX         = 9'd511;
  localparam logic [DISP_W-1:0]  TOL_RESET       = 8'd1;
  localparam logic [DISP_W-1:0]  MISMATCH_VALUE  = 8'd0;
  localparam logic [DISP_W-1:0]  OCCLUSION_VALUE = 8'd255;

  localparam logic [CLASS_W-1:0] CLASS_CONSISTENT = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MISMATCH   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OCCLUSION  = 2'd2;

  typedef struct packed {
    logic [DISP_W-1:0] value;
    logic              valid;
    logic              match;
  } slot_t;

endpackage

>>> design/lrcc_in_if.sv
interface lrcc_in_if
  import lrcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DISP_W-1:0] left_disp;
  logic [DISP_W-1:0] right_disp;
  logic              row_start;

  modport source (output valid, left_disp, right_disp, row_start, input ready);
  modport sink   (input valid, left_disp, right_disp, row_start, output ready);
endinterface

>>> design/lrcc_out_if.sv
interface lrcc_out_if
  import lrcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DISP_W-1:0]  out_disp;
  logic [CLASS_W-1:0] pixel_class;

  modport source (output valid, out_disp, pixel_class, input ready);
  modport sink   (input valid, out_disp, pixel_class, output ready);
endinterface

>>> design/lrcc_ram.sv
module lrcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/lrcc_cell.sv
module lrcc_cell
  import lrcc_pkg::*;
#(
  parameter int OFFSET = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  logic  clear,
  input  slot_t prev,
  output slot_t stored
);

  logic valid_next;

  assign valid_next = prev.valid && !clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored.valid <= 1'b0;
      stored.match <= 1'b0;
    end else if (shift) begin
      stored.value <= prev.value;
      stored.valid <= valid_next;
      stored.match <= valid_next && (prev.value == OFFSET[DISP_W-1:0]);
    end
  end

endmodule

>>> design/left_right_consistency_check_core.sv
// Left/right disparity consistency check for a raster pixel stream. Each input word carries
// the left and right disparity of one column and a row-start flag; each yields one result
// word: the left disparity when the right view agrees within match_tolerance, 0 for a
// mismatch, 255 for an occlusion. One word is taken per clock unless results stall; a word passes
// s1 and the output register. The right-disparity lookup at column minus left disparity goes
// through a 256-entry circular RAM with a registered read, and the occlusion search runs in
// a row of SEARCH_MAX+1 shifting cells that each flag a right disparity equal to their own
// offset. No clearing pass is needed after reset or at a row start. Write match_tolerance
// only while no word is in flight.
module left_right_consistency_check_core
  import lrcc_pkg::*;
#(
  parameter int SEARCH_MAX = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [DISP_W-1:0] cfg_data,
  lrcc_in_if.sink           pixel,
  lrcc_out_if.source        result
);

  localparam int NCELL = SEARCH_MAX + 1;

  logic [DISP_W-1:0] match_tolerance;
  logic              accept;
  logic [COL_W-1:0]  column_count;
  logic [COL_W-1:0]  column_count_next;
  logic [COL_W-1:0]  col;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  raddr;
  logic [DISP_W-1:0] ram_rdata;

  logic              s1_valid;
  logic              s1_adv;
  logic [DISP_W-1:0] s1_left;
  logic [DISP_W-1:0] s1_right;
  logic              s1_in_range;
  logic              s1_left_zero;

  logic              out_valid;
  logic [DISP_W-1:0] out_disp;
  logic [CLASS_W-1:0] pixel_class;
  logic [DISP_W-1:0] out_disp_next;
  logic [CLASS_W-1:0] pixel_class_next;

  slot_t             slots [NCELL];
  slot_t             head;
  logic [NCELL-1:0]  hits;
  logic              hit;
  logic [DISP_W-1:0] other;
  logic [DISP_W-1:0] diff;
  logic              consistent;

  assign s1_adv      = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_adv;
  assign accept      = pixel.valid && pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
    end else if (cfg_write) begin
      match_tolerance <= cfg_data;
    end
  end

  // column of the current word and the saturating count for the next one
  assign col = pixel.row_start ? '0 : column_count;
  assign column_count_next = (col == COL_MAX) ? col : col + COL_W'(1);
  assign raddr = wptr - pixel.left_disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      wptr         <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      wptr         <= wptr + PTR_W'(1);
    end
  end

  lrcc_ram #(
    .WIDTH(DISP_W),
    .DEPTH(WIN_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (accept),
    .waddr(wptr),
    .wdata(pixel.right_disp),
    .re   (accept),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  assign head.value = pixel.right_disp;
  assign head.valid = 1'b1;
  assign head.match = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      lrcc_cell #(.OFFSET(i)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (1'b0),
        .prev  (head),
        .stored(slots[i])
      );
    end else begin : g_body
      lrcc_cell #(.OFFSET(i)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (pixel.row_start),
        .prev  (slots[i-1]),
        .stored(slots[i])
      );
    end
    assign hits[i] = slots[i].match;
  end

  assign hit = |hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left      <= pixel.left_disp;
      s1_right     <= pixel.right_disp;
      s1_in_range  <= {1'b0, pixel.left_disp} <= col;
      s1_left_zero <= pixel.left_disp == '0;
    end
  end

  // the current word's own right value is not yet readable from the RAM
  assign other      = s1_left_zero ? s1_right : ram_rdata;
  assign diff       = (s1_left > other) ? s1_left - other : other - s1_left;
  assign consistent = s1_in_range && (diff <= match_tolerance);

  always_comb begin
    if (consistent) begin
      out_disp_next    = s1_left;
      pixel_class_next = CLASS_CONSISTENT;
    end else if (hit) begin
      out_disp_next    = MISMATCH_VALUE;
      pixel_class_next = CLASS_MISMATCH;
    end else begin
      out_disp_next    = OCCLUSION_VALUE;
      pixel_class_next = CLASS_OCCLUSION;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_disp    <= out_disp_next;
      pixel_class <= pixel_class_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_disp    = out_disp;
  assign result.pixel_class = pixel_class;

  a_row_start_count: assert property (@(posedge clk) disable iff (rst)
    accept && pixel.row_start |=> column_count == COL_W'(1))
    else $error("column count not restarted by row start");

  a_head_slot: assert property (@(posedge clk) disable iff (rst)
    accept |=> slots[0].valid && slots[0].value == $past(pixel.right_disp))
    else $error("head cell did not take the new right disparity");

  a_wptr_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> wptr == $past(wptr) + PTR_W'(1))
    else $error("window pointer out of step with accepted words");

  a_class_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && pixel_class != CLASS_CONSISTENT |->
      (pixel_class == CLASS_MISMATCH && out_disp == MISMATCH_VALUE) ||
      (pixel_class == CLASS_OCCLUSION && out_disp == OCCLUSION_VALUE))
    else $error("result class and disparity disagree");

endmodule
